// ===== hw/rtl/mpmp_pkg.sv =====
// Shared types, constants and helpers for the min-plus matrix power block.
package mpmp_pkg;

	localparam int ValW = 63;
	localparam int ExpBitsDefault = 60;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 63;

	localparam logic [CfgIdxW-1:0] REG_ROW0 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ROW1 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ROW2 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ROW3 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_THRESH = 3'd4;

	localparam logic [ValW-1:0] SatMax = {ValW{1'b1}};

	typedef logic [ValW-1:0] val_t;

	// Saturating add of two values below 2^63.
	function automatic val_t sat_add(input val_t a, input val_t b);
		logic [ValW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ValW] ? SatMax : s[ValW-1:0];
	endfunction

	// Minimum of the four sums of a row element and a column element.
	function automatic val_t min4(input val_t s0, input val_t s1, input val_t s2,
		input val_t s3);
		val_t m0;
		val_t m1;
		m0 = (s0 < s1) ? s0 : s1;
		m1 = (s2 < s3) ? s2 : s3;
		return (m0 < m1) ? m0 : m1;
	endfunction

endpackage

// ===== hw/rtl/mpmp_dot.sv =====
// One min-plus dot product: a row of A against a column of B, registered.
module mpmp_dot (
	input  logic                clk,
	input  mpmp_pkg::val_t      a_row [4],
	input  mpmp_pkg::val_t      b_col [4],
	output mpmp_pkg::val_t      res_q
);

	mpmp_pkg::val_t sums [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sums[k] = mpmp_pkg::sat_add(a_row[k], b_col[k]);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= mpmp_pkg::min4(sums[0], sums[1], sums[2], sums[3]);
	end

endmodule

// ===== hw/rtl/min_plus_matrix_power_check.sv =====
// Min-plus 4x4 matrix power by repeated squaring with threshold check.
//
// Usage: load the base matrix through the write port (registers 0 to 3 hold
// one row each, column 0 in the low byte; register 4 holds the threshold).
// Then offer an exponent on the input channel (valid/ready). Exponent zero
// acts as one and bits above EXP_BITS are ignored. One result transfer
// follows each input transfer, carrying min_entry and all_reach.
// Matrices live in two 16-entry memories (accumulator and base power) with
// a registered read. Each product first copies its operands from memory
// into register snapshots, then one dot-product unit computes and writes
// the entries one at a time, each in a dot phase and a write phase. Per bit
// of exponent-1 the block does one squaring and, when the bit is set, one
// accumulate. From the input transfer to out_valid the block loads the base
// matrix, runs the products, scans the accumulator and registers the result.
// One item is worked at a time. A result waits in the output register while
// the receiver stalls, and the next item is already accepted then; its
// result then waits until the stalled one leaves. Reset clears all control
// state and the configuration registers; the memories are loaded per item.
module min_plus_matrix_power_check #(
	parameter int EXP_BITS = mpmp_pkg::ExpBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mpmp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mpmp_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [EXP_BITS-1:0]           exponent,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mpmp_pkg::ValW-1:0]     min_entry,
	output logic                          all_reach
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic OP_ACC = 1'b0;
	localparam logic OP_SQR = 1'b1;

	logic [31:0] row_q [4];
	mpmp_pkg::val_t thresh_q;

	logic [2:0] state_q;
	logic [EXP_BITS-1:0] rest_q;
	logic op_q;
	logic [3:0] ent_q;
	logic [3:0] k_q;
	logic [1:0] ph_q;
	logic [4:0] scan_q;
	mpmp_pkg::val_t best_q;
	logic reach_q;

	// Two matrices; each product needs all of A row and B column, held in
	// 16-entry register copies (snapshots) refreshed from memory per product.
	mpmp_pkg::val_t acc_mem [16];
	mpmp_pkg::val_t base_mem [16];
	mpmp_pkg::val_t acc_rd_s1;
	mpmp_pkg::val_t base_rd_s1;
	mpmp_pkg::val_t a_snap_q [16];
	mpmp_pkg::val_t b_snap_q [16];

	mpmp_pkg::val_t a_row [4];
	mpmp_pkg::val_t b_col [4];
	mpmp_pkg::val_t dot_res;

	logic mem_we;
	logic mem_sel_acc;
	logic [3:0] mem_waddr;
	mpmp_pkg::val_t mem_wdata;
	logic [3:0] mem_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) row_q[r] <= '0;
			thresh_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mpmp_pkg::REG_ROW0:   row_q[0] <= cfg_data[31:0];
				mpmp_pkg::REG_ROW1:   row_q[1] <= cfg_data[31:0];
				mpmp_pkg::REG_ROW2:   row_q[2] <= cfg_data[31:0];
				mpmp_pkg::REG_ROW3:   row_q[3] <= cfg_data[31:0];
				mpmp_pkg::REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			a_row[k] = a_snap_q[{ent_q[3:2], k[1:0]}];
			b_col[k] = b_snap_q[{k[1:0], ent_q[1:0]}];
		end
	end

	mpmp_dot u_dot (
		.clk   (clk),
		.a_row (a_row),
		.b_col (b_col),
		.res_q (dot_res)
	);

	// Memory control: load phase writes both, multiply phase writes the target.
	always_comb begin
		mem_we = 1'b0;
		mem_sel_acc = 1'b0;
		mem_waddr = ent_q;
		mem_wdata = dot_res;
		mem_raddr = (state_q == ST_SCAN) ? scan_q[3:0] : k_q;
		if (state_q == ST_LOAD) begin
			mem_we = 1'b1;
			mem_wdata = {55'd0, row_q[ent_q[3:2]][8*ent_q[1:0] +: 8]};
		end else if (state_q == ST_MUL && ph_q == 2'd3) begin
			mem_we = 1'b1;
			mem_sel_acc = (op_q == OP_ACC);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && (state_q == ST_LOAD || mem_sel_acc)) acc_mem[mem_waddr] <= mem_wdata;
		if (mem_we && (state_q == ST_LOAD || !mem_sel_acc)) base_mem[mem_waddr] <= mem_wdata;
		acc_rd_s1 <= acc_mem[mem_raddr];
		base_rd_s1 <= base_mem[mem_raddr];
	end

	// ph 0: sweep k_q reading memory into snapshots (finished in ph 1), ph 2: dot, ph 3: write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rest_q <= '0;
			op_q <= OP_SQR;
			ent_q <= '0;
			k_q <= '0;
			ph_q <= '0;
			scan_q <= '0;
			best_q <= '0;
			reach_q <= 1'b0;
			out_valid <= 1'b0;
			min_entry <= '0;
			all_reach <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						rest_q <= (exponent == '0) ? '0 : exponent - 1'b1;
						ent_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ent_q <= ent_q + 4'd1;
					if (ent_q == 4'd15) begin
						if (rest_q == '0) begin
							state_q <= ST_SCAN;
							scan_q <= '0;
						end else begin
							state_q <= ST_MUL;
							op_q <= rest_q[0] ? OP_ACC : OP_SQR;
							k_q <= '0;
							ph_q <= 2'd0;
						end
					end
				end
				ST_MUL: begin
					case (ph_q)
						2'd0: begin
							// Snapshot sweep: memory address k_q, data in the next cycle.
							k_q <= k_q + 4'd1;
							if (k_q == 4'd15) ph_q <= 2'd1;
							ent_q <= k_q;
						end
						2'd1: begin
							ent_q <= 4'd0;
							ph_q <= 2'd2;
						end
						2'd2: ph_q <= 2'd3;
						default: begin
							ent_q <= ent_q + 4'd1;
							ph_q <= 2'd2;
							if (ent_q == 4'd15) begin
								ph_q <= 2'd0;
								k_q <= '0;
								if (op_q == OP_ACC) begin
									op_q <= OP_SQR;
								end else begin
									rest_q <= rest_q >> 1;
									if ((rest_q >> 1) == '0) begin
										state_q <= ST_SCAN;
										scan_q <= '0;
									end else begin
										op_q <= rest_q[1] ? OP_ACC : OP_SQR;
									end
								end
							end
						end
					endcase
				end
				ST_SCAN: begin
					scan_q <= scan_q + 5'd1;
					if (scan_q == 5'd1) begin
						best_q <= acc_rd_s1;
						reach_q <= !(acc_rd_s1 < thresh_q);
					end else if (scan_q != 5'd0) begin
						if (acc_rd_s1 < best_q) best_q <= acc_rd_s1;
						if (acc_rd_s1 < thresh_q) reach_q <= 1'b0;
					end
					if (scan_q == 5'd16) state_q <= ST_DONE;
				end
				default: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						min_entry <= best_q;
						all_reach <= reach_q;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Snapshot capture: during the sweep, data for address k arrives in the next cycle.
	logic snap_we;
	assign snap_we = (state_q == ST_MUL) && (ph_q == 2'd1 || (ph_q == 2'd0 && k_q != 4'd0));

	always_ff @(posedge clk) begin
		if (snap_we) begin
			a_snap_q[ent_q] <= (op_q == OP_ACC) ? acc_rd_s1 : base_rd_s1;
			b_snap_q[ent_q] <= base_rd_s1;
		end
	end

	// The scan fetches address scan_q[3:0]; the last read lands at scan_q 16.
	assign in_ready = (state_q == ST_IDLE);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_LOAD))
		else $error("accepted item did not start loading");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(min_entry)))
		else $error("stalled result changed");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("ready while busy");

	a_mul_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (rest_q != '0))
		else $error("multiply with no exponent bits left");

endmodule
